// File: rtl/clht_pkg.sv
// Shared widths and codes for the circular log head/tail tracker.
`timescale 1ns / 1ps
package clht_pkg;

	localparam int IDX_W       = 8;
	localparam int TIME_W      = 63;
	localparam int MAGIC_W     = 32;
	localparam int CNT_W       = 9;
	localparam int IDX_LIMIT   = 256;
	localparam int MAX_BUCKETS_DEF = 256;

	localparam logic [MAGIC_W-1:0] HDR_MAGIC = 32'h392F389A;
	localparam logic [CNT_W-1:0]   CNT_RESET = 9'd256;

	// Request opcodes
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_SAVE = 1'b1;

	// Result kinds
	localparam logic KIND_SCAN = 1'b0;
	localparam logic KIND_SAVE = 1'b1;

endpackage

// File: rtl/clht_req_if.sv
// Request channel: scan reports and save commits.
`timescale 1ns / 1ps
interface clht_req_if
	import clht_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [IDX_W-1:0]   bucket_index;
	logic [MAGIC_W-1:0] header_magic;
	logic [TIME_W-1:0]  end_time;
	logic               write_ok;

	modport source (output valid, opcode, bucket_index, header_magic, end_time, write_ok,
		input ready);
	modport sink (input valid, opcode, bucket_index, header_magic, end_time, write_ok,
		output ready);
endinterface

// File: rtl/clht_rsp_if.sv
// Result channel: head and tail pointers after a scan or save.
`timescale 1ns / 1ps
interface clht_rsp_if
	import clht_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             result_kind;
	logic             have_data;
	logic [IDX_W-1:0] newest_index;
	logic [IDX_W-1:0] oldest_index;
	logic [IDX_W-1:0] next_write_index;

	modport source (output valid, result_kind, have_data, newest_index, oldest_index,
		next_write_index, input ready);
	modport sink (input valid, result_kind, have_data, newest_index, oldest_index,
		next_write_index, output ready);
endinterface

// File: rtl/clht_cfg_if.sv
// Configuration write channel for the bucket count register.
`timescale 1ns / 1ps
interface clht_cfg_if
	import clht_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: rtl/circular_log_head_tail_tracker.sv
// Top level: ring bucket tracker with one bucket memory and a backward walk sequencer.
`timescale 1ns / 1ps
// Tracks the newest and oldest valid buckets of a circular flash log.
// Channels: req (sink) carries scan reports in ascending bucket order and save
// commits; rsp (source) returns one result for each save and for the scan of
// the last bucket; cfg (sink) writes the bucket count and is always ready.
// Each bucket's valid mark and end time live in one synchronous memory with a
// registered read; the end-of-scan walk reads it back one bucket per cycle.
// A scan of any bucket but the last is taken in the idle state and gives no
// result. A save passes through the emit state into the output register. When
// a valid header was seen, the last scan passes fetch, up to count-1 walk steps
// and emit, as the walk is bound by the single memory read port.
// Throughput: scans of other buckets are taken every cycle while the sequencer is idle.
// A new request is taken once the previous one has left the sequencer, even
// while the last result still sits in the output register; if the receiver
// stalls with a result held, a further result waits in the sequencer and req
// is held not ready until the output register drains.
// Reset clears the pointers and sets the count to 256; the memory is not
// cleared and holds nothing meaningful until the scan writes it.
module circular_log_head_tail_tracker
	import clht_pkg::*;
#(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	clht_req_if.sink  req,
	clht_rsp_if.source rsp,
	clht_cfg_if.sink  cfg
);

	localparam int DEPTH = (MAX_BUCKETS < IDX_LIMIT) ? MAX_BUCKETS : IDX_LIMIT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] LIM = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  newest_q;
	logic [IDX_W-1:0]  oldest_q;
	logic              ptrs_valid_q;
	logic [TIME_W-1:0] best_q;
	logic [TIME_W-1:0] cur_q;
	logic [IDX_W-1:0]  walk_idx_q;
	logic [CNT_W-1:0]  steps_q;
	logic              kind_q;

	logic              rsp_vld_q;
	logic              rsp_kind_q;
	logic              rsp_have_q;
	logic [IDX_W-1:0]  rsp_newest_q;
	logic [IDX_W-1:0]  rsp_oldest_q;
	logic [IDX_W-1:0]  rsp_next_q;

	logic [TIME_W:0]   mem [0:DEPTH-1];
	logic [TIME_W:0]   rd_q;

	logic [CNT_W-1:0]  n_eff;
	logic              req_xfer;
	logic              scan_hit;
	logic              scan_last;
	logic              magic_ok;
	logic              base_valid;
	logic [TIME_W-1:0] base_best;
	logic [IDX_W-1:0]  base_newest;
	logic              take;
	logic [IDX_W-1:0]  scan_newest;
	logic [TIME_W-1:0] scan_best;
	logic              scan_ptrs;
	logic [IDX_W-1:0]  save_next;
	logic [IDX_W-1:0]  walk_prev;
	logic              walk_cond;
	logic              walk_go;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic              slot_free;

	function automatic logic [IDX_W-1:0] step_next(input logic [IDX_W-1:0] i,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] inc;
		inc = {1'b0, i} + CNT_W'(1);
		return (inc >= n) ? '0 : inc[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] step_prev(input logic [IDX_W-1:0] i,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] top;
		top = n - CNT_W'(1);
		return (i == '0 || {1'b0, i} >= n) ? top[IDX_W-1:0] : i - IDX_W'(1);
	endfunction

	// Clamp the bucket count to 1..DEPTH
	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_q > LIM) begin
			n_eff = LIM;
		end else begin
			n_eff = count_q;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_xfer  = req.valid && req.ready;

	// Scan bookkeeping: index zero restarts the newest search
	assign scan_hit    = (req.opcode == OP_SCAN) && ({1'b0, req.bucket_index} < n_eff);
	assign scan_last   = ({1'b0, req.bucket_index} == n_eff - CNT_W'(1));
	assign magic_ok    = (req.header_magic == HDR_MAGIC);
	assign base_valid  = (req.bucket_index == '0) ? 1'b0 : ptrs_valid_q;
	assign base_best   = (req.bucket_index == '0) ? '0 : best_q;
	assign base_newest = (req.bucket_index == '0) ? '0 : newest_q;
	assign take        = magic_ok && (!base_valid || req.end_time > base_best);
	assign scan_newest = take ? req.bucket_index : base_newest;
	assign scan_best   = take ? req.end_time : base_best;
	assign scan_ptrs   = base_valid || take;

	assign save_next = step_next(newest_q, n_eff);

	// Walk: continue while the previous bucket is valid and strictly older, within count-1 steps and short of the newest
	assign walk_prev = step_prev(walk_idx_q, n_eff);
	assign walk_cond = ({1'b0, steps_q} + (CNT_W + 1)'(1) < {1'b0, n_eff}) &&
		(walk_idx_q != newest_q);
	assign walk_go   = walk_cond && rd_q[TIME_W] && (rd_q[TIME_W-1:0] < cur_q);

	assign mem_we = req_xfer && scan_hit;
	assign mem_re = (state_q == ST_FETCH) || ((state_q == ST_WALK) && walk_go);
	assign mem_ra = (state_q == ST_FETCH) ? walk_idx_q[AW-1:0] : walk_prev[AW-1:0];

	// Bucket memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[req.bucket_index[AW-1:0]] <= {magic_ok, req.end_time};
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// Count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			count_q <= cfg.data;
		end
	end

	assign slot_free = !rsp_vld_q || rsp.ready;

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			newest_q     <= '0;
			oldest_q     <= '0;
			ptrs_valid_q <= 1'b0;
			best_q       <= '0;
			cur_q        <= '0;
			walk_idx_q   <= '0;
			steps_q      <= '0;
			kind_q       <= KIND_SCAN;
			rsp_vld_q    <= 1'b0;
		end else begin
			// Drop the held result once it transfers, unless a new one loads now
			if (rsp.ready && state_q != ST_EMIT) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer && req.opcode == OP_SAVE) begin
						kind_q  <= KIND_SAVE;
						state_q <= ST_EMIT;
						if (req.write_ok) begin
							if (!ptrs_valid_q) begin
								newest_q     <= '0;
								oldest_q     <= '0;
								ptrs_valid_q <= 1'b1;
							end else begin
								newest_q <= save_next;
								if (save_next == oldest_q) begin
									oldest_q <= step_next(oldest_q, n_eff);
								end
							end
						end
					end else if (req_xfer && scan_hit) begin
						newest_q     <= scan_newest;
						// Oldest follows a new candidate, a restart or the walk start
						if (take || scan_last || req.bucket_index == '0) begin
							oldest_q <= scan_newest;
						end
						best_q       <= scan_best;
						ptrs_valid_q <= scan_ptrs;
						kind_q       <= KIND_SCAN;
						cur_q        <= scan_best;
						walk_idx_q   <= step_prev(scan_newest, n_eff);
						steps_q      <= '0;
						if (scan_last) begin
							state_q <= scan_ptrs ? ST_FETCH : ST_EMIT;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_go) begin
						oldest_q   <= walk_idx_q;
						cur_q      <= rd_q[TIME_W-1:0];
						walk_idx_q <= walk_prev;
						steps_q    <= steps_q + CNT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						rsp_vld_q    <= 1'b1;
						rsp_kind_q   <= kind_q;
						rsp_have_q   <= ptrs_valid_q;
						rsp_newest_q <= ptrs_valid_q ? newest_q : '0;
						rsp_oldest_q <= ptrs_valid_q ? oldest_q : '0;
						rsp_next_q   <= ptrs_valid_q ? save_next : '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid            = rsp_vld_q;
	assign rsp.result_kind      = rsp_kind_q;
	assign rsp.have_data        = rsp_have_q;
	assign rsp.newest_index     = rsp_newest_q;
	assign rsp.oldest_index     = rsp_oldest_q;
	assign rsp.next_write_index = rsp_next_q;

	// The walk time never exceeds the newest bucket's time
	a_walk_time: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cur_q <= best_q))
		else $error("walk time exceeds newest time");

	// The walk stays within count-1 steps
	a_walk_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (steps_q < n_eff))
		else $error("walk ran past the ring");

	// Memory is written only from a fresh request
	a_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE))
		else $error("bucket write outside idle");

	// A result leaving the sequencer shows up on rsp next cycle
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && slot_free) |=> (rsp.valid && state_q == ST_IDLE))
		else $error("result lost on emit");

endmodule

// File: test/clht_checker.sv
// Checker for the circular log tracker: mirrors bucket and pointer state and compares results.
`timescale 1ns / 1ps
module clht_checker
	import clht_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	clht_req_if  req,
	clht_rsp_if  rsp,
	clht_cfg_if  cfg,
	output int   fails,
	output int   pending
);

	typedef struct packed {
		logic             kind;
		logic             have;
		logic [IDX_W-1:0] newest;
		logic [IDX_W-1:0] oldest;
		logic [IDX_W-1:0] next_wr;
	} ring_ptrs_t;

	// Mirrored bucket headers and ring pointers
	logic              mark_ok   [IDX_LIMIT];
	logic [TIME_W-1:0] mark_time [IDX_LIMIT];
	logic [IDX_W-1:0]  head;
	logic [IDX_W-1:0]  tail;
	logic              have;
	logic [TIME_W-1:0] top_time;
	logic [CNT_W-1:0]  count_reg;

	ring_ptrs_t ptr_q[$];

	// Clamp the count register to the usable ring size
	function automatic int ring_size();
		if (count_reg == '0)
			return 1;
		if (count_reg > CNT_W'(IDX_LIMIT))
			return IDX_LIMIT;
		return int'(count_reg);
	endfunction

	function automatic int ring_next(input int i, input int n);
		return (i + 1 >= n) ? 0 : i + 1;
	endfunction

	// Pointers at or past the end step back to the last bucket
	function automatic int ring_prev(input int i, input int n);
		return (i == 0 || i >= n) ? n - 1 : i - 1;
	endfunction

	function automatic ring_ptrs_t ring_report(input logic kind, input int n);
		ring_ptrs_t r;
		r.kind    = kind;
		r.have    = have;
		r.newest  = have ? head : '0;
		r.oldest  = have ? tail : '0;
		r.next_wr = have ? IDX_W'(ring_next(int'(head), n)) : '0;
		return r;
	endfunction

	// Update the mirror for one accepted request and queue its result, if any
	task automatic track_item(input logic op, input logic [IDX_W-1:0] idx,
		input logic [MAGIC_W-1:0] magic, input logic [TIME_W-1:0] t, input logic ok);
		int n;
		int i;
		int steps;
		logic [TIME_W-1:0] cur;
		logic [IDX_W-1:0] nx;
		logic hit;
		n = ring_size();
		if (op == OP_SCAN) begin
			// drop scans past the end of the ring
			if (int'(idx) >= n)
				return;
			hit = (magic == HDR_MAGIC);
			if (idx == '0) begin
				head     = '0;
				tail     = '0;
				have     = 1'b0;
				top_time = '0;
			end
			mark_ok[idx]   = hit;
			mark_time[idx] = t;
			// first strictly greater time wins, ties keep the earlier bucket
			if (hit && (!have || t > top_time)) begin
				head     = idx;
				tail     = idx;
				top_time = t;
				have     = 1'b1;
			end
			if (int'(idx) != n - 1)
				return;
			// walk back from newest while end times strictly decrease
			if (have) begin
				tail  = head;
				cur   = top_time;
				i     = ring_prev(int'(head), n);
				steps = 0;
				while (steps + 1 < n && i != int'(head)) begin
					if (!(mark_ok[i] && mark_time[i] < cur))
						break;
					tail = IDX_W'(i);
					cur  = mark_time[i];
					i    = ring_prev(i, n);
					steps++;
				end
			end
			ptr_q.push_back(ring_report(KIND_SCAN, n));
		end else begin
			// advance newest on a good write, push oldest ahead when caught
			if (ok) begin
				if (!have) begin
					head = '0;
					tail = '0;
					have = 1'b1;
				end else begin
					nx   = IDX_W'(ring_next(int'(head), n));
					head = nx;
					if (nx == tail)
						tail = IDX_W'(ring_next(int'(tail), n));
				end
			end
			ptr_q.push_back(ring_report(KIND_SAVE, n));
		end
	endtask

	// Compare one result transfer against the oldest queued prediction
	task automatic check_result();
		ring_ptrs_t want;
		if (ptr_q.size() == 0) begin
			$error("unexpected result: result_kind %0d newest_index %0d",
				rsp.result_kind, rsp.newest_index);
			fails++;
			return;
		end
		want = ptr_q.pop_front();
		if (rsp.result_kind !== want.kind) begin
			$error("result_kind expected %0d actual %0d", want.kind, rsp.result_kind);
			fails++;
		end
		if (rsp.have_data !== want.have) begin
			$error("have_data expected %0d actual %0d", want.have, rsp.have_data);
			fails++;
		end
		if (rsp.newest_index !== want.newest) begin
			$error("newest_index expected %0d actual %0d", want.newest, rsp.newest_index);
			fails++;
		end
		if (rsp.oldest_index !== want.oldest) begin
			$error("oldest_index expected %0d actual %0d", want.oldest, rsp.oldest_index);
			fails++;
		end
		if (rsp.next_write_index !== want.next_wr) begin
			$error("next_write_index expected %0d actual %0d", want.next_wr,
				rsp.next_write_index);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < IDX_LIMIT; k++) begin
				mark_ok[k]   = 1'b0;
				mark_time[k] = '0;
			end
			head      = '0;
			tail      = '0;
			have      = 1'b0;
			top_time  = '0;
			count_reg = CNT_RESET;
			ptr_q.delete();
			fails     = 0;
			pending   = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				count_reg = cfg.data;
			if (req.valid && req.ready)
				track_item(req.opcode, req.bucket_index, req.header_magic, req.end_time,
					req.write_ok);
			if (rsp.valid && rsp.ready)
				check_result();
			pending = ptr_q.size();
		end
	end

endmodule

// File: test/tb_circular_log_head_tail_tracker.sv
// Testbench top: drives scan and save traffic into the head/tail tracker and gives the verdict.
`timescale 1ns / 1ps
module tb_circular_log_head_tail_tracker;
	import clht_pkg::*;

	localparam int WATCH_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1700;

	logic clk = 1'b0;
	logic arst_n;

	clht_req_if req ();
	clht_rsp_if rsp ();
	clht_cfg_if cfg ();

	int fails;
	int pending;
	int idle_pct;
	int stall_pct;
	int ring_n;
	int live_items;
	int quiet = 0;
	bit written [IDX_LIMIT];

	always #10 clk = ~clk;

	circular_log_head_tail_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	clht_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.fails   (fails),
		.pending (pending)
	);

	// Stall the result channel at the current rate
	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= stall_pct);

	// Abort when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
			(cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet == WATCH_LIMIT) begin
			$display("tb_circular_log_head_tail_tracker: FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	function automatic logic [MAGIC_W-1:0] pick_magic(input int good_pct);
		if ($urandom_range(99) < good_pct)
			return HDR_MAGIC;
		case ($urandom_range(2))
			0: return '0;
			1: return HDR_MAGIC ^ (MAGIC_W'(1) << $urandom_range(MAGIC_W - 1));
			default: return MAGIC_W'($urandom);
		endcase
	endfunction

	// The finish walk may only touch buckets that a scan has written
	function automatic bit can_finish();
		for (int j = 0; j < ring_n - 1; j++)
			if (!written[j])
				return 1'b0;
		return 1'b1;
	endfunction

	// Hold one request until its transfer; keep valid high into the next item
	task automatic put_req(input logic op, input logic [IDX_W-1:0] idx,
		input logic [MAGIC_W-1:0] magic, input logic [TIME_W-1:0] t, input logic ok);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.bucket_index <= idx;
		req.header_magic <= magic;
		req.end_time     <= t;
		req.write_ok     <= ok;
		do @(posedge clk); while (!req.ready);
		if (op == OP_SCAN && int'(idx) >= ring_n)
			return;
		if (op == OP_SCAN)
			written[idx] = 1'b1;
		live_items++;
	endtask

	task automatic scan(input logic [IDX_W-1:0] idx, input logic [MAGIC_W-1:0] magic,
		input logic [TIME_W-1:0] t);
		put_req(OP_SCAN, idx, magic, t, logic'($urandom_range(1)));
	endtask

	task automatic save(input logic ok);
		put_req(OP_SAVE, IDX_W'($urandom), MAGIC_W'($urandom), rand_time(), ok);
	endtask

	// Drop valid and wait for every queued result, then let the block settle
	task automatic drain(input int settle);
		req.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_count(input int value);
		drain(8);
		cfg.valid <= 1'b1;
		cfg.data  <= CNT_W'(value);
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		ring_n = value;
	endtask

	task automatic set_mode(input int m);
		case (m)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 87;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 87;
			end
			default: begin
				idle_pct  = 19;
				stall_pct = 19;
			end
		endcase
	endtask

	// One ascending scan of the whole ring with random headers and stray saves, then a few saves
	task automatic scan_pass();
		int s;
		int style;
		int saves;
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] stride;
		logic [TIME_W-1:0] t;
		s      = $urandom_range(ring_n - 1);
		style  = $urandom_range(3);
		base   = rand_time() >> 12;
		stride = TIME_W'($urandom_range(1000, 1));
		for (int i = 0; i < ring_n; i++) begin
			case (style)
				// rotated ascending log, wraps at a random bucket
				0: t = base + TIME_W'((i - s + ring_n) % ring_n) * stride;
				1: t = TIME_W'($urandom_range(3));
				2: t = rand_time();
				default: t = $urandom_range(1) ? '1 : '0;
			endcase
			if ($urandom_range(99) < 8)
				t = rand_time();
			if ($urandom_range(99) < 6)
				save($urandom_range(99) < 80);
			scan(IDX_W'(i), pick_magic(88), t);
		end
		saves = $urandom_range((ring_n < 8) ? ring_n + 2 : 10);
		repeat (saves) save($urandom_range(99) < 85);
	endtask

	// Short burst of stray saves, out-of-range scans and out-of-order scans
	task automatic noise();
		int idx;
		repeat ($urandom_range(6, 1)) begin
			case ($urandom_range(9))
				0, 1, 2: save($urandom_range(1));
				3, 4: begin
					if (ring_n < IDX_LIMIT)
						scan(IDX_W'($urandom_range(IDX_LIMIT - 1, ring_n)), pick_magic(50),
							rand_time());
					else
						save(1'b1);
				end
				default: begin
					idx = $urandom_range(ring_n - 1);
					if (idx == ring_n - 1 && !can_finish())
						idx = $urandom_range(ring_n - 2);
					scan(IDX_W'(idx), pick_magic(60),
						$urandom_range(1) ? rand_time() : TIME_W'($urandom_range(3)));
				end
			endcase
		end
	endtask

	initial begin
		int phase;
		int goal;
		int stop;
		int pick;
		bit paused;
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.opcode       = OP_SCAN;
		req.bucket_index = '0;
		req.header_magic = '0;
		req.end_time     = '0;
		req.write_ok     = 1'b0;
		cfg.valid        = 1'b0;
		cfg.data         = '0;
		idle_pct         = 0;
		stall_pct        = 0;
		ring_n           = int'(CNT_RESET);
		live_items       = 0;
		paused           = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Saves with no data: failed write, first good write, then an advance
		save(1'b0);
		save(1'b1);
		save(1'b1);

		// Single bucket ring: the scan of bucket 0 finishes at once
		set_count(1);
		scan(8'd0, HDR_MAGIC, '1);
		scan(8'd255, HDR_MAGIC, '0);
		save(1'b1);
		save(1'b0);

		// Four buckets: walk wraps past bucket 0, then a save overtakes oldest
		set_count(4);
		scan(8'd0, HDR_MAGIC, 63'd10);
		scan(8'd1, HDR_MAGIC, 63'd20);
		scan(8'd2, HDR_MAGIC, 63'd3);
		scan(8'd3, HDR_MAGIC, 63'd7);
		save(1'b1);

		// Tie on the top time, save mid-scan, near-miss magic and read failure
		scan(8'd0, HDR_MAGIC, '1);
		save(1'b1);
		scan(8'd1, HDR_MAGIC, '1);
		scan(8'd2, HDR_MAGIC ^ 32'h1, 63'd5);
		scan(8'd3, '0, '0);

		// Ring with no valid header at all
		scan(8'd0, '1, '0);
		scan(8'd1, '0, '1);
		scan(8'd2, '0, 63'd1);
		scan(8'd3, '1, '1);

		// Random phases over ring sizes and idle patterns
		goal  = live_items + RANDOM_ITEMS;
		phase = 0;
		while (live_items < goal) begin
			pick = $urandom_range(99);
			if (phase == 0)
				set_count(IDX_LIMIT);
			else if (phase == 1)
				set_count(1);
			else if (pick < 60)
				set_count($urandom_range(6, 1));
			else if (pick < 85)
				set_count($urandom_range(24, 7));
			else if (pick < 97)
				set_count($urandom_range(64, 25));
			else
				set_count(IDX_LIMIT);
			set_mode(phase % 4);
			stop = live_items + ((phase == 0) ? 1 : 120);
			while (live_items < stop && live_items < goal) begin
				if (phase == 0 || $urandom_range(99) < 80)
					scan_pass();
				else
					noise();
				// hold off once until everything outstanding has come back
				if (phase == 2 && !paused) begin
					drain(1);
					paused = 1'b1;
				end
			end
			phase++;
		end

		set_mode(0);
		drain(300);
		if (fails == 0 && pending == 0)
			$display("tb_circular_log_head_tail_tracker: PASS");
		else
			$display("tb_circular_log_head_tail_tracker: FAIL");
		$finish;
	end

endmodule
